### hw/rtl/sse_pkg.sv
// sse_pkg: shared constants and controller/datapath interface structs
// for the selection sort engine. No dependencies.
`default_nettype none

package sse_pkg;

    // Default set size and element width
    localparam int unsigned COUNT_DEF = 16;
    localparam int unsigned VALUE_W   = 16;

    // Controller -> datapath commands
    typedef struct packed {
        logic load_wr;   // input transfer: write value at load index
        logic scan_rd;   // read next element of the unsorted prefix
        logic wr_hi;     // write largest into last unsorted slot
        logic wr_lo;     // write displaced element into largest's slot
        logic out_rd;    // read next sorted element
        logic out_ld;    // load read data into output register
        logic out_xfer;  // output transfer completes this cycle
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic last_load; // load index at final slot of the set
        logic scan_end;  // scan index has reached the pass limit
        logic last_pass; // current pass is the final one
        logic out_last;  // output index at final element
    } t_status;

endpackage

`default_nettype wire

### hw/rtl/sse_ram.sv
// sse_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none

module sse_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hw/rtl/sse_dp.sv
// sse_dp: selection sort datapath - element RAM, indexes, running max,
// output register. Depends on sse_pkg and sse_ram.
`default_nettype none

module sse_dp #(
    parameter int unsigned COUNT = sse_pkg::COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sse_pkg::t_cmd               i_cmd,
    output sse_pkg::t_status                 o_status,
    input  wire logic [sse_pkg::VALUE_W-1:0] i_value,
    output logic                             o_out_valid,
    output logic      [sse_pkg::VALUE_W-1:0] o_sorted_value,
    output logic                             o_last_out
);

    localparam int unsigned IW = $clog2(COUNT);
    localparam logic [IW-1:0] LAST_IDX = IW'(COUNT - 1);
    localparam logic [IW-1:0] ONE_IDX  = IW'(1);

    logic [IW-1:0]               r_load_cnt;
    logic [IW-1:0]               r_limit;
    logic [IW-1:0]               r_k;
    logic                        r_cmp_vld;
    logic [IW-1:0]               r_cmp_idx;
    logic [sse_pkg::VALUE_W-1:0] r_best;
    logic [IW-1:0]               r_best_at;
    logic [sse_pkg::VALUE_W-1:0] r_held;
    logic [IW-1:0]               r_out_idx;
    logic [sse_pkg::VALUE_W-1:0] r_out_val;
    logic                        r_out_last;
    logic                        r_out_vld;

    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    logic [sse_pkg::VALUE_W-1:0] wr_data;
    logic                        rd_en;
    logic [IW-1:0]               rd_addr;
    logic [sse_pkg::VALUE_W-1:0] rd_data;

    // single write port shared by load and the two swap writes
    always_comb begin
        wr_en   = i_cmd.load_wr | i_cmd.wr_hi | i_cmd.wr_lo;
        wr_addr = r_best_at;
        wr_data = r_held;
        if (i_cmd.load_wr) begin
            wr_addr = r_load_cnt;
            wr_data = i_value;
        end else if (i_cmd.wr_hi) begin
            wr_addr = r_limit;
            wr_data = r_best;
        end
        rd_en   = i_cmd.scan_rd | i_cmd.out_rd;
        rd_addr = i_cmd.scan_rd ? r_k : r_out_idx;
    end

    sse_ram #(
        .WIDTH (sse_pkg::VALUE_W),
        .DEPTH (COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_limit    <= LAST_IDX;
            r_k        <= '0;
            r_cmp_vld  <= 1'b0;
            r_out_idx  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
            if (i_cmd.load_wr) begin
                if (o_status.last_load) begin
                    r_load_cnt <= '0;
                    r_limit    <= LAST_IDX;
                    r_k        <= '0;
                end else begin
                    r_load_cnt <= r_load_cnt + ONE_IDX;
                end
            end
            if (i_cmd.scan_rd) begin
                r_k <= r_k + ONE_IDX;
            end
            if (i_cmd.wr_lo) begin
                r_k <= '0;
                if (o_status.last_pass) begin
                    r_out_idx <= '0;
                end else begin
                    r_limit <= r_limit - ONE_IDX;
                end
            end
            if (i_cmd.out_ld) begin
                r_out_vld <= 1'b1;
            end else if (i_cmd.out_xfer) begin
                r_out_vld <= 1'b0;
                r_out_idx <= r_out_idx + ONE_IDX;
            end
        end
    end

    // payload: running max (first largest wins), held tail element, output
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_k;
        if (r_cmp_vld) begin
            if ((r_cmp_idx == '0) || (rd_data > r_best)) begin
                r_best    <= rd_data;
                r_best_at <= r_cmp_idx;
            end
            if (r_cmp_idx == r_limit) begin
                r_held <= rd_data;
            end
        end
        if (i_cmd.out_ld) begin
            r_out_val  <= rd_data;
            r_out_last <= o_status.out_last;
        end
    end

    assign o_status.last_load = (r_load_cnt == LAST_IDX);
    assign o_status.scan_end  = (r_k == r_limit);
    assign o_status.last_pass = (r_limit == ONE_IDX);
    assign o_status.out_last  = (r_out_idx == LAST_IDX);

    assign o_out_valid    = r_out_vld;
    assign o_sorted_value = r_out_val;
    assign o_last_out     = r_out_last;

    a_swap_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_hi |=> i_cmd.wr_lo)
        else $error("swap high write not followed by low write");

    a_cmp_in_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_cmp_idx <= r_limit))
        else $error("compare beyond unsorted prefix");

    a_xfer_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_xfer |-> r_out_vld)
        else $error("output transfer without valid data");

    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_wr |-> !r_out_vld)
        else $error("load while a result is pending");

endmodule

`default_nettype wire

### hw/rtl/sse_ctrl.sv
// sse_ctrl: selection sort controller FSM - load, scan/swap passes,
// output sequencing. Depends on sse_pkg.
`default_nettype none

module sse_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_out_stall,
    input  wire sse_pkg::t_status i_status,
    output sse_pkg::t_cmd         o_cmd
);

    localparam logic [2:0] S_LOAD     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_DRAIN    = 3'd2;
    localparam logic [2:0] S_WR_HI    = 3'd3;
    localparam logic [2:0] S_WR_LO    = 3'd4;
    localparam logic [2:0] S_OUT_RD   = 3'd5;
    localparam logic [2:0] S_OUT_LD   = 3'd6;
    localparam logic [2:0] S_OUT_WAIT = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_wr  = (r_state == S_LOAD) && i_in_valid;
        o_cmd.scan_rd  = (r_state == S_SCAN);
        o_cmd.wr_hi    = (r_state == S_WR_HI);
        o_cmd.wr_lo    = (r_state == S_WR_LO);
        o_cmd.out_rd   = (r_state == S_OUT_RD);
        o_cmd.out_ld   = (r_state == S_OUT_LD);
        o_cmd.out_xfer = (r_state == S_OUT_WAIT) && !i_out_stall;
        o_in_stall     = (r_state != S_LOAD);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (o_cmd.load_wr && i_status.last_load) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_WR_HI;
            end
            S_WR_HI: begin
                n_state = S_WR_LO;
            end
            S_WR_LO: begin
                n_state = i_status.last_pass ? S_OUT_RD : S_SCAN;
            end
            S_OUT_RD: begin
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (o_cmd.out_xfer) begin
                    n_state = i_status.out_last ? S_LOAD : S_OUT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    a_stall_outside_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> o_in_stall)
        else $error("input open during sort");

    a_last_load_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_wr && i_status.last_load) |=> (r_state == S_SCAN))
        else $error("sort did not start after final load");

endmodule

`default_nettype wire

### hw/rtl/selection_sort_engine.sv
// selection_sort_engine: top level - collects a set of values, sorts them
// ascending, streams them out. Depends on sse_pkg, sse_ctrl, sse_dp.
`default_nettype none

// The engine takes COUNT unsigned 16-bit values, one per input transfer, and
// writes them into a COUNT-entry element RAM. The transfer that carries the
// COUNT-th value starts the sort: each pass scans the unsorted prefix through
// the RAM's single read port, one element per cycle, keeping the first
// largest value, then swaps it into the last unsorted slot with two writes.
// After COUNT-1 passes the COUNT values are sent out in ascending order, one
// per output transfer, with o_last_out set on the final one; the engine then
// takes the next set. Each output value takes a RAM read, an output register
// load and a transfer. o_in_stall is high from the final input transfer until
// the last result has been taken; i_out_stall may hold a result indefinitely,
// and o_sorted_value and o_last_out stay stable while it does. COUNT may
// range from 2 to 64.
module selection_sort_engine #(
    parameter int unsigned COUNT = sse_pkg::COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [sse_pkg::VALUE_W-1:0] i_value,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [sse_pkg::VALUE_W-1:0] o_sorted_value,
    output logic                             o_last_out
);

    sse_pkg::t_cmd    cmd;
    sse_pkg::t_status status;

    // sequencing: load, scan/swap passes, output
    sse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // element RAM, indexes, running max and output register
    sse_dp #(
        .COUNT (COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out)
    );

endmodule

`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking bench for selection_sort_engine. Streams sets of
// 16-bit values in, predicts the ascending output stream, checks every result.
// Depends on sse_pkg and selection_sort_engine.
`timescale 1ns / 1ps

module tb_top;

    localparam int SET_SIZE    = sse_pkg::COUNT_DEF;
    localparam int VW          = sse_pkg::VALUE_W;
    localparam int NUM_SETS    = 14;      // one directed set + random sets
    localparam int HOLD_CYCLES = 400;     // long output hold-off
    localparam int HOLD_AT     = 35;      // result count that triggers it
    localparam int DRAIN_WAIT  = 300;     // quiet cycles after the last result
    localparam int CYCLE_LIMIT = 200000;

    // shape of the values inside one set
    typedef enum int {
        SET_RANDOM,
        SET_EQUAL,
        SET_ASCENDING,
        SET_DESCENDING,
        SET_FEW_VALUES,
        SET_EXTREMES
    } t_set_kind;

    // one entry of the send queue: a value, or a marker that makes the
    // sender hold until every predicted result has been taken
    typedef struct {
        bit            pause;
        logic [VW-1:0] value;
    } t_send_item;

    typedef struct {
        logic [VW-1:0] value;
        logic          last;
    } t_sorted_item;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic [VW-1:0] i_value     = '0;
    logic          i_out_stall = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    logic [VW-1:0] o_sorted_value;
    logic          o_last_out;

    t_send_item   send_queue[$];
    t_sorted_item pending_sorted[$];

    // predictor state: the set being collected
    logic [VW-1:0] set_store [SET_SIZE];
    int            set_fill = 0;

    int in_issued   = 0;   // values put on the input bus (driver)
    int in_taken    = 0;   // input transfers seen (monitor)
    int out_taken   = 0;   // output transfers seen (monitor)
    int out_seen    = 0;   // receiver's copy of out_taken
    int in_gap      = 0;
    int out_wait    = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int pauses_done = 0;
    int err_count   = 0;
    int cycle_count = 0;

    logic [VW-1:0] directed_vals [SET_SIZE] = '{
        16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE,
        16'hFFFF, 16'h0000, 16'h1234, 16'h1234, 16'h00FF, 16'hFF00, 16'h8001, 16'h7FFE
    };

    selection_sort_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out)
    );

    always #5 i_clk = ~i_clk;

    // Collect one value; on the last value of a set, sort the set the same
    // way the engine does (each pass moves the first largest element of the
    // unsorted prefix into the prefix's last slot) and queue the results.
    task automatic absorb_value(input logic [VW-1:0] v);
        int            pass;
        int            lim;
        int            k;
        int            best_at;
        logic [VW-1:0] best;
        logic [VW-1:0] held;
        set_store[set_fill] = v;
        set_fill++;
        if (set_fill == SET_SIZE) begin
            for (pass = 0; pass < SET_SIZE - 1; pass++) begin
                lim     = SET_SIZE - pass;
                best    = set_store[0];
                best_at = 0;
                for (k = 0; k < lim; k++) begin
                    if (set_store[k] > best) begin    // strict: keep first largest
                        best    = set_store[k];
                        best_at = k;
                    end
                end
                held                = set_store[lim-1];
                set_store[lim-1]    = set_store[best_at];
                set_store[best_at]  = held;
            end
            for (k = 0; k < SET_SIZE; k++)
                pending_sorted.push_back('{set_store[k], (k == SET_SIZE - 1)});
            set_fill = 0;
        end
    endtask

    // Queue one full set of values of the given shape.
    task automatic queue_set(input t_set_kind kind);
        int            i;
        int            acc;
        logic [VW-1:0] v;
        logic [VW-1:0] pick [3];
        v   = VW'($urandom);
        acc = (kind == SET_DESCENDING) ? 65535 - int'($urandom_range(0, 1000))
                                       : int'($urandom_range(0, 1000));
        for (i = 0; i < 3; i++)
            pick[i] = VW'($urandom);
        for (i = 0; i < SET_SIZE; i++) begin
            case (kind)
                SET_RANDOM: begin
                    v = VW'($urandom);
                end
                SET_EQUAL: begin
                    // same value throughout: v was drawn once above
                end
                SET_ASCENDING: begin
                    v   = VW'(acc);
                    acc = acc + int'($urandom_range(0, 4000));
                    if (acc > 65535) acc = 65535;
                end
                SET_DESCENDING: begin
                    v   = VW'(acc);
                    acc = acc - int'($urandom_range(0, 4000));
                    if (acc < 0) acc = 0;
                end
                SET_FEW_VALUES: begin
                    v = pick[$urandom_range(0, 2)];
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       v = 16'h0000;
                        1:       v = 16'h0001;
                        2:       v = 16'hFFFE;
                        default: v = 16'hFFFF;
                    endcase
                end
            endcase
            send_queue.push_back('{1'b0, v});
        end
    endtask

    // Stimulus plan and end of run.
    initial begin : main_seq
        int        s;
        t_set_kind kind;
        // directed set: field extremes, single-bit and alternating patterns,
        // duplicated maximum and minimum, duplicated middle value
        foreach (directed_vals[i])
            send_queue.push_back('{1'b0, directed_vals[i]});
        for (s = 1; s < NUM_SETS; s++) begin
            // first few random sets hit the degenerate orderings for sure
            if (s == 1)      kind = SET_EQUAL;
            else if (s == 2) kind = SET_DESCENDING;
            else if (s == 3) kind = SET_ASCENDING;
            else if ($urandom_range(0, 9) < 4) kind = SET_RANDOM;
            else kind = t_set_kind'($urandom_range(1, 5));
            queue_set(kind);
            // sender waits for a fully drained engine at these set boundaries
            if (s == 4 || s == 9)
                send_queue.push_back('{1'b1, '0});
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (send_queue.size() != 0 || in_taken != in_issued)
            @(posedge i_clk);
        while (pending_sorted.size() != 0)
            @(posedge i_clk);
        // any output after this point is a spurious result
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d sets of %0d values (directed extremes, equal, ascending,",
                 NUM_SETS, SET_SIZE);
        $display("descending, few-distinct, random): %0d results, %0d drain pauses, %0d errors",
                 out_taken, pauses_done, err_count);
        if (err_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Input driver: presents values at the falling edge. A presented value
    // stays put until the monitor has counted its transfer; between values
    // the sender idles a random number of cycles, except in burst sets.
    always @(negedge i_clk) begin : drive_input
        t_send_item item;
        if (i_rst_n) begin
            if (i_in_valid && in_taken != in_issued) begin
                // stalled: hold the current value
            end else if (in_gap > 0) begin
                i_in_valid <= 1'b0;
                in_gap--;
            end else if (send_queue.size() != 0 && send_queue[0].pause
                         && pending_sorted.size() != 0) begin
                i_in_valid <= 1'b0;
            end else begin
                if (send_queue.size() != 0 && send_queue[0].pause) begin
                    item = send_queue.pop_front();
                    pauses_done++;
                end
                if (send_queue.size() != 0) begin
                    item = send_queue.pop_front();
                    i_value    <= item.value;
                    i_in_valid <= 1'b1;
                    in_issued++;
                    // every fourth set goes in back to back
                    in_gap = ((in_issued / SET_SIZE) % 4 == 2) ? 0 : $urandom_range(0, 13);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here: once, mid-way through a set's
    // output, the receiver stalls for HOLD_CYCLES while the sender keeps
    // offering the next set, so the engine must hold its input stalled.
    always @(posedge i_clk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && out_taken == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Output receiver: after each transfer it draws how many valid cycles to
    // stall before taking the next result; every fourth set drains at full rate.
    always @(negedge i_clk) begin : drive_stall
        logic stall_now;
        if (out_taken != out_seen) begin
            out_seen = out_taken;
            out_wait = ((out_taken / SET_SIZE) % 4 == 1) ? 0 : $urandom_range(0, 13);
        end
        stall_now = (hold_left > 0) || (o_out_valid && out_wait > 0);
        if (hold_left == 0 && o_out_valid && out_wait > 0)
            out_wait--;
        i_out_stall <= stall_now;
    end

    // Monitor: checks output transfers against the oldest prediction first,
    // then feeds input transfers to the predictor.
    always @(posedge i_clk) begin : monitor
        t_sorted_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_sorted.size() == 0) begin
                    $error("unexpected result: sorted_value %h last_out %b",
                           o_sorted_value, o_last_out);
                    err_count++;
                end else begin
                    want = pending_sorted.pop_front();
                    if (o_sorted_value !== want.value) begin
                        $error("sorted_value: expected %h, actual %h",
                               want.value, o_sorted_value);
                        err_count++;
                    end
                    if (o_last_out !== want.last) begin
                        $error("last_out: expected %b, actual %b", want.last, o_last_out);
                        err_count++;
                    end
                end
                out_taken <= out_taken + 1;
            end
            if (i_in_valid && !o_in_stall) begin
                absorb_value(i_value);
                in_taken <= in_taken + 1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

endmodule
